// ===== src/dga_pkg.sv =====
// Shared types and helpers for the Gregorian date arithmetic block.
// Holds the control word, status and result structs and the calendar tables.
// No dependencies.
package dga_pkg;

    // Top year the add walk may reach before it saturates.
    localparam int unsigned YEAR_MAX = 9999;

    // Saturation bounds of the 23-bit signed day difference
    localparam logic signed [24:0] DIFF_MAX = 25'sd4194303;
    localparam logic signed [24:0] DIFF_MIN = -25'sd4194304;

    // Datapath operations, one per microcode step
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_YEAR_Q,
        OP_YEAR_LEAP,
        OP_WALK,
        OP_ACC_A,
        OP_ACC_B,
        OP_MUL_YEARS,
        OP_ACC_PROD,
        OP_EMIT
    } alu_op_t;

    // Control driven by the sequencer each cycle
    typedef struct packed {
        logic    take_in;
        alu_op_t op;
    } ctrl_t;

    // Datapath flags that steer the sequencer's jumps
    typedef struct packed {
        logic is_diff;
        logic walk_done;
        logic month_wrap;
    } status_t;

    // One result item
    typedef struct packed {
        logic        overflow;
        logic [22:0] day_difference;
        logic [13:0] year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
    } result_t;

    // Days in a month; invalid month codes count as 31 days.
    function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
        logic [4:0] n;
        unique case (m)
            4'd2:                      n = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
            default:                   n = 5'd31;
        endcase
        return n;
    endfunction

    // Days in the months before month m of a year, invalid codes included.
    function automatic logic [8:0] days_before_month(logic [3:0] m, logic leap);
        logic [8:0] n;
        unique case (m)
            4'd0:    n = 9'd0;
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            4'd13:   n = 9'd365;
            4'd14:   n = 9'd396;
            default: n = 9'd427;
        endcase
        // February lies before every month above two
        if (leap && (m > 4'd2))
        begin
            n = n + 9'd1;
        end
        return n;
    endfunction

endpackage

// ===== src/dga_sequencer.sv =====
// Microcode sequencer: step counter, control store and jump logic.
// Drives the datapath op for each step from a read-only program.
// Depends on dga_pkg.
module dga_sequencer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             out_busy,
    input  dga_pkg::status_t status,
    output dga_pkg::ctrl_t   ctrl
);
    import dga_pkg::*;

    typedef logic [3:0] step_t;

    typedef enum logic [2:0] {
        JC_NEXT,
        JC_ALWAYS,
        JC_WAIT_IN,
        JC_IF_DIFF,
        JC_WALK,
        JC_WAIT_OUT
    } jump_t;

    typedef struct packed {
        logic    take_in;
        alu_op_t op;
        jump_t   jc;
        step_t   target;
    } ucode_t;

    // Program addresses
    localparam step_t ST_IDLE     = 4'd0;
    localparam step_t ST_LOAD     = 4'd1;
    localparam step_t ST_ADD_YQ   = 4'd2;
    localparam step_t ST_ADD_YL   = 4'd3;
    localparam step_t ST_WALK     = 4'd4;
    localparam step_t ST_WRAP_YQ  = 4'd5;
    localparam step_t ST_DIF_YQ_A = 4'd6;
    localparam step_t ST_DIF_YL_A = 4'd7;
    localparam step_t ST_ACC_A    = 4'd8;
    localparam step_t ST_DIF_YQ_B = 4'd9;
    localparam step_t ST_DIF_YL_B = 4'd10;
    localparam step_t ST_ACC_B    = 4'd11;
    localparam step_t ST_MUL      = 4'd12;
    localparam step_t ST_ACC_PROD = 4'd13;
    localparam step_t ST_EMIT     = 4'd14;

    // Control store
    function automatic ucode_t ucode_rom(step_t pc);
        ucode_t w;
        unique case (pc)
            ST_IDLE:     w = '{1'b1, OP_NOP,       JC_WAIT_IN,  ST_IDLE};
            ST_LOAD:     w = '{1'b0, OP_LOAD,      JC_IF_DIFF,  ST_DIF_YQ_A};
            ST_ADD_YQ:   w = '{1'b0, OP_YEAR_Q,    JC_NEXT,     ST_IDLE};
            ST_ADD_YL:   w = '{1'b0, OP_YEAR_LEAP, JC_NEXT,     ST_IDLE};
            ST_WALK:     w = '{1'b0, OP_WALK,      JC_WALK,     ST_EMIT};
            ST_WRAP_YQ:  w = '{1'b0, OP_YEAR_Q,    JC_ALWAYS,   ST_ADD_YL};
            ST_DIF_YQ_A: w = '{1'b0, OP_YEAR_Q,    JC_NEXT,     ST_IDLE};
            ST_DIF_YL_A: w = '{1'b0, OP_YEAR_LEAP, JC_NEXT,     ST_IDLE};
            ST_ACC_A:    w = '{1'b0, OP_ACC_A,     JC_NEXT,     ST_IDLE};
            ST_DIF_YQ_B: w = '{1'b0, OP_YEAR_Q,    JC_NEXT,     ST_IDLE};
            ST_DIF_YL_B: w = '{1'b0, OP_YEAR_LEAP, JC_NEXT,     ST_IDLE};
            ST_ACC_B:    w = '{1'b0, OP_ACC_B,     JC_NEXT,     ST_IDLE};
            ST_MUL:      w = '{1'b0, OP_MUL_YEARS, JC_NEXT,     ST_IDLE};
            ST_ACC_PROD: w = '{1'b0, OP_ACC_PROD,  JC_NEXT,     ST_IDLE};
            ST_EMIT:     w = '{1'b0, OP_EMIT,      JC_WAIT_OUT, ST_IDLE};
            default:     w = '{1'b0, OP_NOP,       JC_ALWAYS,   ST_IDLE};
        endcase
        return w;
    endfunction

    step_t  pc_reg;
    step_t  pc_next;
    ucode_t uword;

    assign uword        = ucode_rom(pc_reg);
    assign ctrl.take_in = uword.take_in;
    assign ctrl.op      = uword.op;

    // Pick the next step
    always_comb
    begin
        unique case (uword.jc)
            JC_NEXT:     pc_next = pc_reg + 4'd1;
            JC_ALWAYS:   pc_next = uword.target;
            JC_WAIT_IN:  pc_next = in_valid ? pc_reg + 4'd1 : pc_reg;
            JC_IF_DIFF:  pc_next = status.is_diff ? uword.target : pc_reg + 4'd1;
            JC_WALK:
            begin
                if (status.walk_done)
                begin
                    pc_next = uword.target;
                end
                else if (status.month_wrap)
                begin
                    pc_next = pc_reg + 4'd1;
                end
                else
                begin
                    pc_next = pc_reg;
                end
            end
            JC_WAIT_OUT: pc_next = out_busy ? pc_reg : uword.target;
            default:     pc_next = ST_IDLE;
        endcase
    end

    // Advance the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= ST_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== src/dga_datapath.sv =====
// Datapath for date arithmetic: request registers, month walk, year unit
// (leap flag and leap-year count) and the difference accumulator.
// Depends on dga_pkg; steered by dga_sequencer.
module dga_datapath (
    input  logic             clk,
    input  dga_pkg::ctrl_t   ctrl,
    input  logic             in_fire,
    input  logic             operation,
    input  logic [4:0]       day_a,
    input  logic [3:0]       month_a,
    input  logic [13:0]      year_a,
    input  logic [4:0]       day_b,
    input  logic [3:0]       month_b,
    input  logic [13:0]      year_b,
    input  logic [15:0]      add_days,
    output dga_pkg::status_t status,
    output dga_pkg::result_t result
);
    import dga_pkg::*;

    // Request registers
    logic        op_reg;
    logic [4:0]  da_reg;
    logic [3:0]  ma_reg;
    logic [13:0] ya_reg;
    logic [4:0]  db_reg;
    logic [3:0]  mb_reg;
    logic [13:0] yb_reg;
    logic [15:0] nd_reg;

    // Working registers
    logic [16:0]        d_reg;
    logic [3:0]         m_reg;
    logic [13:0]        y_reg;
    logic               ovf_reg;
    logic [7:0]         q_reg;
    logic               leap_reg;
    logic [11:0]        lb_reg;
    logic signed [24:0] acc_reg;
    logic signed [23:0] prod_reg;

    logic [26:0]        q_prod;
    logic [13:0]        rem100;
    logic               r_zero;
    logic               y_lo_zero;
    logic               leap_calc;
    logic [12:0]        lb_calc;
    logic [4:0]         mlen;
    logic [9:0]         doy_a;
    logic [9:0]         doy_b;
    logic signed [14:0] dy;

    // Year unit: y / 100 by reciprocal, exact for all 14-bit years
    assign q_prod    = 27'(y_reg) * 27'd5243;
    assign rem100    = y_reg - 14'(q_reg) * 14'd100;
    assign r_zero    = (rem100 == 14'd0);
    assign y_lo_zero = (y_reg[1:0] == 2'b00);
    assign leap_calc = (y_lo_zero && !r_zero) || (r_zero && (q_reg[1:0] == 2'b00));

    // Leap years in [0, y): ceil(y/4) - ceil(y/100) + ceil(y/400)
    assign lb_calc = 13'(y_reg[13:2]) + 13'(!y_lo_zero)
                   - 13'(q_reg) - 13'(!r_zero)
                   + 13'(q_reg[7:2]) + 13'((q_reg[1:0] != 2'b00) || !r_zero);

    assign mlen  = month_len(m_reg, leap_reg);
    assign doy_a = 10'(da_reg) + 10'(days_before_month(ma_reg, leap_reg));
    assign doy_b = 10'(db_reg) + 10'(days_before_month(mb_reg, leap_reg));
    assign dy    = $signed({1'b0, ya_reg}) - $signed({1'b0, yb_reg});

    assign status.is_diff    = op_reg;
    assign status.walk_done  = ovf_reg || (d_reg <= 17'(mlen));
    assign status.month_wrap = (m_reg >= 4'd12);

    // Capture the request item
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg <= operation;
            da_reg <= day_a;
            ma_reg <= month_a;
            ya_reg <= year_a;
            db_reg <= day_b;
            mb_reg <= month_b;
            yb_reg <= year_b;
            nd_reg <= add_days;
        end
    end

    // Execute the current step
    always_ff @(posedge clk)
    begin
        unique case (ctrl.op)
            OP_LOAD:
            begin
                d_reg   <= 17'(da_reg) + 17'(nd_reg);
                m_reg   <= ma_reg;
                y_reg   <= ya_reg;
                ovf_reg <= (17'(ya_reg) > 17'(YEAR_MAX));
                acc_reg <= '0;
            end
            OP_YEAR_Q:
            begin
                q_reg <= q_prod[26:19];
            end
            OP_YEAR_LEAP:
            begin
                leap_reg <= leap_calc;
                lb_reg   <= lb_calc[11:0];
            end
            OP_WALK:
            begin
                // Step one month forward while the day spills over
                if (!status.walk_done)
                begin
                    d_reg <= d_reg - 17'(mlen);
                    if (status.month_wrap)
                    begin
                        m_reg   <= 4'd1;
                        y_reg   <= y_reg + 14'd1;
                        ovf_reg <= ((17'(y_reg) + 17'd1) > 17'(YEAR_MAX));
                    end
                    else
                    begin
                        m_reg <= m_reg + 4'd1;
                    end
                end
            end
            OP_ACC_A:
            begin
                acc_reg <= acc_reg + $signed(25'(lb_reg)) + $signed(25'(doy_a));
                y_reg   <= yb_reg;
            end
            OP_ACC_B:
            begin
                acc_reg <= acc_reg - $signed(25'(lb_reg)) - $signed(25'(doy_b));
            end
            OP_MUL_YEARS:
            begin
                prod_reg <= 24'(dy) * 24'sd365;
            end
            OP_ACC_PROD:
            begin
                acc_reg <= acc_reg + 25'(prod_reg);
            end
            default:
            begin
            end
        endcase
    end

    // Form the result item
    always_comb
    begin
        result = '0;
        if (op_reg)
        begin
            if (acc_reg > DIFF_MAX)
            begin
                result.day_difference = 23'(DIFF_MAX);
            end
            else if (acc_reg < DIFF_MIN)
            begin
                result.day_difference = 23'(DIFF_MIN);
            end
            else
            begin
                result.day_difference = acc_reg[22:0];
            end
        end
        else if (ovf_reg)
        begin
            result.day_out   = 5'd31;
            result.month_out = 4'd12;
            result.year_out  = 14'(YEAR_MAX);
            result.overflow  = 1'b1;
        end
        else
        begin
            result.day_out   = d_reg[4:0];
            result.month_out = m_reg;
            result.year_out  = y_reg;
        end
    end

endmodule

// ===== src/gregorian_date_arithmetic.sv =====
// Gregorian date arithmetic: add days to a date, or count days between dates.
// Each request item is handled one at a time. Difference mode runs a fixed
// program from acceptance to result: the year unit runs once per date and
// one 24-bit product of the year gap is added. Add mode walks the date
// forward by one month length per cycle, pausing at each year boundary while
// the shared year unit refreshes the leap flag. The next item is taken once
// the result has been moved into the output register, which holds it while
// the sink stalls.
// Depends on dga_pkg, dga_sequencer and dga_datapath.
module gregorian_date_arithmetic (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // day_a[4:0], month_a[8:5], year_a[22:9], day_b[27:23], month_b[31:28],
    // year_b[45:32], add_days[61:46], zero fill[63:62]
    input  logic [63:0] s_tdata,
    // operation[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // day_out[4:0], month_out[8:5], year_out[22:9], day_difference[45:23],
    // zero fill[47:46]
    output logic [47:0] m_tdata,
    // overflow[0]
    output logic        m_tuser
);
    import dga_pkg::*;

    ctrl_t   ctrl;
    status_t status;
    result_t result;

    logic        in_fire;
    logic        out_busy;
    logic        out_load;
    logic        m_tvalid_reg;
    logic [47:0] m_tdata_reg;
    logic        m_tuser_reg;

    assign s_tready = ctrl.take_in;
    assign in_fire  = s_tvalid && ctrl.take_in;
    assign out_busy = m_tvalid_reg && !m_tready;
    assign out_load = (ctrl.op == OP_EMIT) && !out_busy;

    dga_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .out_busy (out_busy),
        .status   (status),
        .ctrl     (ctrl)
    );

    dga_datapath u_dp (
        .clk       (clk),
        .ctrl      (ctrl),
        .in_fire   (in_fire),
        .operation (s_tuser),
        .day_a     (s_tdata[4:0]),
        .month_a   (s_tdata[8:5]),
        .year_a    (s_tdata[22:9]),
        .day_b     (s_tdata[27:23]),
        .month_b   (s_tdata[31:28]),
        .year_b    (s_tdata[45:32]),
        .add_days  (s_tdata[61:46]),
        .status    (status),
        .result    (result)
    );

    // Hold the result until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= {2'b00, result.day_difference, result.year_out,
                            result.month_out, result.day_out};
            m_tuser_reg <= result.overflow;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef NO_ASSERTIONS
    // One request at a time: no accept in the cycle after an accept
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item accepted while one is in work");

    // A saturated sum always reads as the last day of the top year
    a_ovf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |->
            (m_tdata[4:0] == 5'd31) && (m_tdata[8:5] == 4'd12) &&
            (m_tdata[22:9] == 14'(YEAR_MAX)) && (m_tdata[45:23] == 23'd0))
        else $error("overflow result not saturated");

    // A nonzero difference never comes with date fields or overflow
    a_diff_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[45:23] != 23'd0)) |->
            ((m_tdata[22:0] == 23'd0) && !m_tuser))
        else $error("difference result carries date fields");

    // The result is loaded only from the emit step with a free output
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_EMIT && m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("pending result overwritten");
`endif

endmodule

// ===== tb/sv/gregorian_date_arithmetic_test.sv =====
// Self-checking testbench for gregorian_date_arithmetic: date add and day difference.
// Predicts results the table lacks and checks each one field by field on the output.
// Depends on dga_pkg and the gregorian_date_arithmetic RTL.
module gregorian_date_arithmetic_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic {
        CAL_ADD  = 1'b0,
        CAL_DIFF = 1'b1
    } cal_op_t;

    typedef struct packed {
        cal_op_t     op;
        logic [15:0] add_days;
        logic [13:0] year_b;
        logic [3:0]  month_b;
        logic [4:0]  day_b;
        logic [13:0] year_a;
        logic [3:0]  month_a;
        logic [4:0]  day_a;
    } date_req_t;

    // One row of the directed table; want is used only when typed is set
    typedef struct {
        date_req_t        req;
        bit               typed;
        dga_pkg::result_t want;
    } dir_row_t;

    localparam int     RANDOM_ITEMS = 116;
    localparam longint SPAN_MAX     = 4194303;
    localparam longint SPAN_MIN     = -4194304;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;

    bit               burst = 1'b0;
    int               errors = 0;
    dga_pkg::result_t expected_dates[$];
    dir_row_t         directed_rows[$];

    always #4 clk = ~clk;

    gregorian_date_arithmetic u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Calendar rules of the proleptic Gregorian calendar
    function automatic bit leap_year_of(int unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
    endfunction

    // Month codes outside 1..12 count as 31 days
    function automatic int unsigned month_days(int unsigned m, int unsigned y);
        int unsigned n;
        case (m)
            2:          n = leap_year_of(y) ? 29 : 28;
            4, 6, 9, 11: n = 30;
            default:    n = 31;
        endcase
        return n;
    endfunction

    // Leap years in [0, y)
    function automatic longint leap_years_below(int unsigned y);
        return longint'((y + 3) / 4) - longint'((y + 99) / 100) + longint'((y + 399) / 400);
    endfunction

    function automatic longint ordinal_in_year(int unsigned d, int unsigned m, int unsigned y);
        longint n;
        n = d;
        for (int unsigned k = 1; k < m; k++)
        begin
            n += month_days(k, y);
        end
        return n;
    endfunction

    function automatic dga_pkg::result_t predict_date(date_req_t r);
        dga_pkg::result_t res;
        int unsigned      d;
        int unsigned      m;
        int unsigned      y;
        bit               ovf;
        longint           span;
        res = '0;
        if (r.op == CAL_ADD)
        begin
            d   = r.day_a + r.add_days;
            m   = r.month_a;
            y   = r.year_a;
            ovf = (y > dga_pkg::YEAR_MAX);
            // Walk month by month until the day fits
            while (!ovf && d > month_days(m, y))
            begin
                d -= month_days(m, y);
                m++;
                if (m > 12)
                begin
                    m = 1;
                    y++;
                    if (y > dga_pkg::YEAR_MAX)
                    begin
                        ovf = 1'b1;
                    end
                end
            end
            // Saturate to the last day of the top year
            if (ovf)
            begin
                d = 31;
                m = 12;
                y = dga_pkg::YEAR_MAX;
            end
            res.day_out   = 5'(d);
            res.month_out = 4'(m);
            res.year_out  = 14'(y);
            res.overflow  = ovf;
        end
        else
        begin
            span = (longint'(r.year_a) - longint'(r.year_b)) * 365
                 + (leap_years_below(r.year_a) - leap_years_below(r.year_b))
                 + (ordinal_in_year(r.day_a, r.month_a, r.year_a)
                    - ordinal_in_year(r.day_b, r.month_b, r.year_b));
            if (span > SPAN_MAX)
            begin
                span = SPAN_MAX;
            end
            if (span < SPAN_MIN)
            begin
                span = SPAN_MIN;
            end
            res.day_difference = 23'(span);
        end
        return res;
    endfunction

    function automatic dir_row_t dir_row(cal_op_t op, int da, int ma, int ya,
                                         int db, int mb, int yb, int nd, bit typed,
                                         int eday, int emonth, int eyear, int ediff, bit eovf);
        dir_row_t row;
        row.req.op               = op;
        row.req.day_a            = 5'(da);
        row.req.month_a          = 4'(ma);
        row.req.year_a           = 14'(ya);
        row.req.day_b            = 5'(db);
        row.req.month_b          = 4'(mb);
        row.req.year_b           = 14'(yb);
        row.req.add_days         = 16'(nd);
        row.typed                = typed;
        row.want                 = '0;
        row.want.day_out         = 5'(eday);
        row.want.month_out       = 4'(emonth);
        row.want.year_out        = 14'(eyear);
        row.want.day_difference  = 23'(ediff);
        row.want.overflow        = eovf;
        return row;
    endfunction

    // Mostly valid dates, a few near the top year, some raw field noise
    function automatic void random_date(output logic [4:0] d, output logic [3:0] m,
                                        output logic [13:0] y);
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 3)
        begin
            d = 5'($urandom_range(0, 31));
            m = 4'($urandom_range(0, 15));
            y = 14'($urandom_range(0, 16383));
        end
        else
        begin
            y = (pick < 8) ? 14'($urandom_range(9800, 9999)) : 14'($urandom_range(0, 9999));
            m = 4'($urandom_range(1, 12));
            d = 5'($urandom_range(1, month_days(m, y)));
        end
    endfunction

    function automatic date_req_t random_date_request();
        date_req_t   r;
        int unsigned pick;
        r.op = cal_op_t'($urandom_range(0, 1));
        random_date(r.day_a, r.month_a, r.year_a);
        random_date(r.day_b, r.month_b, r.year_b);
        // Keep most day counts short so the month walk stays quick
        pick = $urandom_range(0, 9);
        if (pick < 7)
        begin
            r.add_days = 16'($urandom_range(0, 800));
        end
        else if (pick < 9)
        begin
            r.add_days = 16'($urandom_range(0, 9999));
        end
        else
        begin
            r.add_days = 16'($urandom_range(0, 65535));
        end
        return r;
    endfunction

    function automatic void compare_field(string name, longint want, longint got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function automatic void check_result(dga_pkg::result_t got);
        dga_pkg::result_t want;
        if (expected_dates.size() == 0)
        begin
            $display("%0t: unexpected result expected none actual %h", $time, got);
            errors++;
        end
        else
        begin
            want = expected_dates.pop_front();
            compare_field("day_out", want.day_out, got.day_out);
            compare_field("month_out", want.month_out, got.month_out);
            compare_field("year_out", want.year_out, got.year_out);
            compare_field("day_difference", longint'($signed(want.day_difference)),
                          longint'($signed(got.day_difference)));
            compare_field("overflow", want.overflow, got.overflow);
        end
    endfunction

    // Present one item after a random gap, none in burst mode, and hold it until accepted
    task automatic send_request(date_req_t r, dga_pkg::result_t want);
        int unsigned gap;
        gap = burst ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.op;
        s_tdata  <= {2'b00, r.add_days, r.year_b, r.month_b, r.day_b,
                     r.year_a, r.month_a, r.day_a};
        do
        begin
            @(posedge clk);
        end
        while (s_tready !== 1'b1);
        expected_dates.push_back(want);
    endtask

    // Stimulus: directed table, then random items, then drain
    initial
    begin
        date_req_t req;
        // op, A (d, m, y), B (d, m, y), days, typed, want (d, m, y, diff, ovf)
        directed_rows.push_back(dir_row(CAL_ADD, 1, 1, 2000, 1, 1, 2000, 0, 1,
                                        1, 1, 2000, 0, 0));
        directed_rows.push_back(dir_row(CAL_ADD, 28, 2, 2000, 31, 15, 16383, 1, 1,
                                        29, 2, 2000, 0, 0));
        directed_rows.push_back(dir_row(CAL_ADD, 28, 2, 1900, 0, 0, 0, 1, 1,
                                        1, 3, 1900, 0, 0));
        directed_rows.push_back(dir_row(CAL_ADD, 31, 12, 9999, 1, 1, 1, 1, 1,
                                        31, 12, 9999, 0, 1));
        directed_rows.push_back(dir_row(CAL_ADD, 1, 1, 16383, 1, 1, 1, 0, 1,
                                        31, 12, 9999, 0, 1));
        directed_rows.push_back(dir_row(CAL_ADD, 1, 1, 0, 1, 1, 1, 65535, 0,
                                        0, 0, 0, 0, 0));
        directed_rows.push_back(dir_row(CAL_ADD, 31, 1, 9999, 1, 1, 1, 65535, 1,
                                        31, 12, 9999, 0, 1));
        directed_rows.push_back(dir_row(CAL_ADD, 0, 0, 0, 1, 1, 1, 0, 1,
                                        0, 0, 0, 0, 0));
        directed_rows.push_back(dir_row(CAL_ADD, 31, 15, 2023, 1, 1, 1, 1, 0,
                                        0, 0, 0, 0, 0));
        directed_rows.push_back(dir_row(CAL_ADD, 31, 0, 2023, 1, 1, 1, 1, 0,
                                        0, 0, 0, 0, 0));
        directed_rows.push_back(dir_row(CAL_ADD, 31, 13, 2023, 1, 1, 1, 0, 1,
                                        31, 13, 2023, 0, 0));
        directed_rows.push_back(dir_row(CAL_ADD, 31, 2, 2001, 1, 1, 1, 0, 0,
                                        0, 0, 0, 0, 0));
        directed_rows.push_back(dir_row(CAL_ADD, 29, 2, 2024, 1, 1, 1, 365, 0,
                                        0, 0, 0, 0, 0));
        directed_rows.push_back(dir_row(CAL_DIFF, 15, 6, 2024, 15, 6, 2024, 0, 1,
                                        0, 0, 0, 0, 0));
        directed_rows.push_back(dir_row(CAL_DIFF, 1, 1, 2000, 31, 12, 1999, 0, 1,
                                        0, 0, 0, 1, 0));
        directed_rows.push_back(dir_row(CAL_DIFF, 31, 12, 1999, 1, 1, 2000, 65535, 1,
                                        0, 0, 0, -1, 0));
        directed_rows.push_back(dir_row(CAL_DIFF, 1, 1, 16383, 1, 1, 0, 0, 1,
                                        0, 0, 0, 4194303, 0));
        directed_rows.push_back(dir_row(CAL_DIFF, 1, 1, 0, 1, 1, 16383, 0, 1,
                                        0, 0, 0, -4194304, 0));
        directed_rows.push_back(dir_row(CAL_DIFF, 31, 12, 9999, 1, 1, 0, 0, 0,
                                        0, 0, 0, 0, 0));
        directed_rows.push_back(dir_row(CAL_DIFF, 1, 3, 2000, 28, 2, 2000, 0, 1,
                                        0, 0, 0, 2, 0));
        directed_rows.push_back(dir_row(CAL_DIFF, 1, 3, 1900, 28, 2, 1900, 0, 1,
                                        0, 0, 0, 1, 0));
        directed_rows.push_back(dir_row(CAL_DIFF, 31, 15, 2023, 0, 0, 2023, 0, 0,
                                        0, 0, 0, 0, 0));
        directed_rows.push_back(dir_row(CAL_DIFF, 1, 1, 1600, 1, 1, 2400, 0, 0,
                                        0, 0, 0, 0, 0));
        directed_rows.push_back(dir_row(CAL_DIFF, 31, 13, 2024, 0, 15, 2024, 0, 0,
                                        0, 0, 0, 0, 0));

        // Hold reset low before releasing it
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (int i = 0; i < directed_rows.size(); i++)
        begin
            burst <= (i >= 12 && i < 18);
            send_request(directed_rows[i].req,
                         directed_rows[i].typed ? directed_rows[i].want
                                                : predict_date(directed_rows[i].req));
        end

        // Random items, with a no-gap stretch every third block of twenty
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            burst <= ((i / 20) % 3 == 2);
            req = random_date_request();
            send_request(req, predict_date(req));
        end
        s_tvalid <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (expected_dates.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (32) @(posedge clk);
        if (errors == 0)
        begin
            $display("gregorian_date_arithmetic: match");
        end
        else
        begin
            $display("gregorian_date_arithmetic: mismatch");
        end
        $finish;
    end

    // Result side: stall a random number of cycles per item, then take it
    initial
    begin
        int unsigned stall;
        forever
        begin
            stall = burst ? 0 : $urandom_range(0, 7);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!(rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1));
            check_result(dga_pkg::result_t'({m_tuser, m_tdata[45:0]}));
        end
    end

    // Give up well past the slowest legal run
    initial
    begin
        #25_000_000;
        $display("gregorian_date_arithmetic: mismatch");
        $finish;
    end

endmodule
